@@ hdl/tsm_pkg.sv @@
// ----------------------------------------------------------------------------
// tsm_pkg - shared types, sizes and ring-address helpers
// Field widths, buffer and stream sizes, the held-word type and the
// control group passed to the watermark unit.
// ----------------------------------------------------------------------------
package tsm_pkg;

   localparam int MAX_STREAMS  = 8;
   localparam int BUFFER_DEPTH = 32;
   localparam int TIME_W       = 64;
   localparam int ID_W         = 8;
   localparam int PAY_W        = 32;
   localparam int SIDX_W       = 3;
   localparam int NCFG_W       = 4;

   localparam int ADDR_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CNT_W   = $clog2(BUFFER_DEPTH + 1);
   localparam int SADDR_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
   localparam int SCNT_W  = $clog2(MAX_STREAMS + 1);

   typedef struct packed {
      logic [TIME_W-1:0] ev_time;
      logic [ID_W-1:0]   ev_id;
      logic [PAY_W-1:0]  ev_payload;
   } entry_type;

   typedef struct packed {
      logic               upd;
      logic [SADDR_W-1:0] upd_idx;
      logic [TIME_W-1:0]  upd_time;
      logic               go;
   } wm_ctl_type;

   function automatic logic [ADDR_W-1:0] ring_inc(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] r;
      if (a == ADDR_W'(BUFFER_DEPTH - 1)) r = '0;
      else r = a + ADDR_W'(1);
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] ring_dec(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] r;
      if (a == '0) r = ADDR_W'(BUFFER_DEPTH - 1);
      else r = a - ADDR_W'(1);
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                  input logic [CNT_W-1:0]  c);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(a) + (CNT_W + 1)'(c);
      if (sum >= (CNT_W + 1)'(BUFFER_DEPTH)) sum = sum - (CNT_W + 1)'(BUFFER_DEPTH);
      return sum[ADDR_W-1:0];
   endfunction

endpackage

@@ hdl/tsm_held_buf.sv @@
// ----------------------------------------------------------------------------
// tsm_held_buf - held-word store
// Ring storage for words waiting on the watermark: one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module tsm_held_buf (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [tsm_pkg::ADDR_W-1:0] wr_addr,
   input  tsm_pkg::entry_type        wr_data,
   input  logic                      rd_en,
   input  logic [tsm_pkg::ADDR_W-1:0] rd_addr,
   output tsm_pkg::entry_type        rd_data
);
   import tsm_pkg::*;

   entry_type mem [BUFFER_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/tsm_watermark.sv @@
// ----------------------------------------------------------------------------
// tsm_watermark - latest-time table and iterative minimum
// Holds each stream's latest timestamp and walks the configured streams
// one a cycle through a single comparator to find the watermark.
// ----------------------------------------------------------------------------
module tsm_watermark (
   input  logic                       clock,
   input  logic                       reset,
   input  tsm_pkg::wm_ctl_type        ctl,
   input  logic [tsm_pkg::SCNT_W-1:0] num_eff,
   output logic [tsm_pkg::TIME_W-1:0] mark,
   output logic                       done
);
   import tsm_pkg::*;

   logic [TIME_W-1:0] latest_ff [MAX_STREAMS];
   logic [TIME_W-1:0] mark_ff, mark_in;
   logic [SCNT_W-1:0] idx_ff, idx_in;
   logic              run_ff, run_in;
   logic [TIME_W-1:0] cand;
   logic              more;

   assign more = idx_ff < num_eff;
   assign cand = latest_ff[idx_ff[SADDR_W-1:0]];
   assign done = run_ff && !more;

   always_comb begin
      mark_in = mark_ff;
      idx_in  = idx_ff;
      run_in  = run_ff;
      if (ctl.go) begin
         if (ctl.upd && ctl.upd_idx == '0) mark_in = ctl.upd_time;
         else mark_in = latest_ff[0];
         idx_in = SCNT_W'(1);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (more) begin
            if (cand < mark_ff) mark_in = cand;
            idx_in = idx_ff + SCNT_W'(1);
         end else begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_STREAMS; k++) latest_ff[k] <= '0;
         run_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         if (ctl.upd) latest_ff[ctl.upd_idx] <= ctl.upd_time;
         run_ff <= run_in;
         idx_ff <= idx_in;
      end
      mark_ff <= mark_in;
   end

   assign mark = mark_ff;

   a_go_only_when_free: assert property (@(posedge clock) disable iff (reset)
      ctl.go |-> !run_ff) else $error("watermark restarted while running");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("watermark done held longer than a cycle");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> idx_ff <= SCNT_W'(MAX_STREAMS)) else $error("stream walk overran");

endmodule

@@ hdl/timestamp_stream_merger_top.sv @@
// After acceptance the insert shifts each held word above the new time up one place, then
// writes the new word (skipped when full, the word then dropped); the watermark walks each
// active stream; release reads and emits each word at or below it; a closing state follows.
// Runs take one event each, busy high for the whole run; the released words are registered,
// the last strobed in the first idle cycle with rsp_last_of_run, if the run released any word; no stall.
// Reset (synchronous, active high) empties the buffer, zeroes stream times, count to 1.
// ----------------------------------------------------------------------------
// timestamp_stream_merger_top - k-way timestamp merge with watermark release
// Sequencer over a ring buffer: sorted insert by shifting, watermark
// minimum, then release of every held word at or below the watermark.
// ----------------------------------------------------------------------------
module timestamp_stream_merger_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [tsm_pkg::SIDX_W-1:0]  req_stream_index,
   input  logic [tsm_pkg::TIME_W-1:0]  req_event_time,
   input  logic [tsm_pkg::ID_W-1:0]    req_event_own_id,
   input  logic [tsm_pkg::PAY_W-1:0]   req_event_payload,
   output logic                        rsp_valid,
   output logic [tsm_pkg::TIME_W-1:0]  rsp_out_time,
   output logic [tsm_pkg::ID_W-1:0]    rsp_out_id,
   output logic [tsm_pkg::PAY_W-1:0]   rsp_out_payload,
   output logic                        rsp_dropped,
   output logic                        rsp_last_of_run,
   input  logic                        csr_write_enable,
   input  logic [tsm_pkg::NCFG_W-1:0]  csr_write_data
);
   import tsm_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_INS_RD  = 3'd1;
   localparam logic [2:0] ST_INS_CMP = 3'd2;
   localparam logic [2:0] ST_MIN     = 3'd3;
   localparam logic [2:0] ST_REL_RD  = 3'd4;
   localparam logic [2:0] ST_REL_CMP = 3'd5;
   localparam logic [2:0] ST_FIN     = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [NCFG_W-1:0] csr_ff;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   entry_type         new_ff, new_in;
   entry_type         pend_ff, pend_in;
   logic              pend_drop_ff, pend_drop_in;
   logic              pend_vld_ff, pend_vld_in;

   logic              rsp_valid_ff;
   entry_type         rsp_word_ff;
   logic              rsp_dropped_ff, rsp_last_ff;

   logic              emit, emit_last;
   logic [SCNT_W-1:0] n_eff;
   logic              accept, in_range;
   entry_type         in_word;

   logic              buf_we, buf_re;
   logic [ADDR_W-1:0] buf_waddr, buf_raddr;
   entry_type         buf_wdata, buf_rdata;

   wm_ctl_type        wm_ctl;
   logic [TIME_W-1:0] mark;
   logic              wm_done;

   always_comb begin
      int n;
      n = int'(csr_ff);
      if (n < 1) n = 1;
      if (n > MAX_STREAMS) n = MAX_STREAMS;
      n_eff = SCNT_W'(n);
   end

   assign busy     = state_ff != ST_IDLE;
   assign accept   = start && !busy;
   assign in_range = int'(req_stream_index) < int'(n_eff);

   always_comb begin
      in_word.ev_time    = req_event_time;
      in_word.ev_payload = req_event_payload;
      if (n_eff > SCNT_W'(1)) in_word.ev_id = ID_W'(req_stream_index);
      else in_word.ev_id = req_event_own_id;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      j_in         = j_ff;
      wr_addr_in   = wr_addr_ff;
      new_in       = new_ff;
      pend_in      = pend_ff;
      pend_drop_in = pend_drop_ff;
      pend_vld_in  = pend_vld_ff;
      emit         = 1'b0;
      emit_last    = 1'b0;
      buf_we       = 1'b0;
      buf_waddr    = wr_addr_ff;
      buf_wdata    = new_ff;
      buf_re       = 1'b0;
      buf_raddr    = head_ff;
      wm_ctl.upd      = 1'b0;
      wm_ctl.upd_idx  = SADDR_W'(req_stream_index);
      wm_ctl.upd_time = req_event_time;
      wm_ctl.go       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && in_range) begin
               wm_ctl.upd = 1'b1;
               new_in     = in_word;
               if (count_ff == CNT_W'(BUFFER_DEPTH)) begin
                  pend_in      = in_word;
                  pend_drop_in = 1'b1;
                  pend_vld_in  = 1'b1;
                  wm_ctl.go    = 1'b1;
                  state_in     = ST_MIN;
               end else begin
                  wr_addr_in = ring_add(head_ff, count_ff);
                  j_in       = count_ff;
                  state_in   = ST_INS_RD;
               end
            end
         end
         ST_INS_RD: begin
            if (j_ff == '0) begin
               buf_we    = 1'b1;
               count_in  = count_ff + CNT_W'(1);
               wm_ctl.go = 1'b1;
               state_in  = ST_MIN;
            end else begin
               buf_re    = 1'b1;
               buf_raddr = ring_dec(wr_addr_ff);
               state_in  = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            buf_we = 1'b1;
            if (buf_rdata.ev_time > new_ff.ev_time) begin
               buf_wdata  = buf_rdata;
               wr_addr_in = ring_dec(wr_addr_ff);
               j_in       = j_ff - CNT_W'(1);
               state_in   = ST_INS_RD;
            end else begin
               count_in  = count_ff + CNT_W'(1);
               wm_ctl.go = 1'b1;
               state_in  = ST_MIN;
            end
         end
         ST_MIN: begin
            if (wm_done) state_in = ST_REL_RD;
         end
         ST_REL_RD: begin
            if (count_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               buf_re   = 1'b1;
               state_in = ST_REL_CMP;
            end
         end
         ST_REL_CMP: begin
            if (buf_rdata.ev_time <= mark) begin
               emit         = pend_vld_ff;
               pend_in      = buf_rdata;
               pend_drop_in = 1'b0;
               pend_vld_in  = 1'b1;
               head_in      = ring_inc(head_ff);
               count_in     = count_ff - CNT_W'(1);
               state_in     = ST_REL_RD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            emit        = pend_vld_ff;
            emit_last   = 1'b1;
            pend_vld_in = 1'b0;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= NCFG_W'(1);
         head_ff      <= '0;
         count_ff     <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_enable) csr_ff <= csr_write_data;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= emit;
      end
      j_ff         <= j_in;
      wr_addr_ff   <= wr_addr_in;
      new_ff       <= new_in;
      pend_ff      <= pend_in;
      pend_drop_ff <= pend_drop_in;
      if (emit) begin
         rsp_word_ff    <= pend_ff;
         rsp_dropped_ff <= pend_drop_ff;
         rsp_last_ff    <= emit_last;
      end
   end

   tsm_held_buf u_buf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data (buf_wdata),
      .rd_en   (buf_re),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   tsm_watermark u_wm (
      .clock   (clock),
      .reset   (reset),
      .ctl     (wm_ctl),
      .num_eff (n_eff),
      .mark    (mark),
      .done    (wm_done)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_time    = rsp_word_ff.ev_time;
   assign rsp_out_id      = rsp_word_ff.ev_id;
   assign rsp_out_payload = rsp_word_ff.ev_payload;
   assign rsp_dropped     = rsp_dropped_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(BUFFER_DEPTH)) else $error("held count overflow");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start)) else $error("busy rose without start");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |=> !rsp_valid) else $error("word after last of run");

   a_cmp_after_rd: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INS_CMP |-> $past(state_ff) == ST_INS_RD)
      else $error("insert compare without read");

endmodule

@@ sim/merge_order_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_order_check - scoreboard for the timestamp stream merger
// Watches the event, result and register ports, keeps its own copy of the
// stream times, the sorted hold buffer and the stream count, predicts every
// word each accepted event releases and compares the words field by field.
// ----------------------------------------------------------------------------
module merge_order_check (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [tsm_pkg::SIDX_W-1:0]  req_stream_index,
   input  logic [tsm_pkg::TIME_W-1:0]  req_event_time,
   input  logic [tsm_pkg::ID_W-1:0]    req_event_own_id,
   input  logic [tsm_pkg::PAY_W-1:0]   req_event_payload,
   input  logic                        rsp_valid,
   input  logic [tsm_pkg::TIME_W-1:0]  rsp_out_time,
   input  logic [tsm_pkg::ID_W-1:0]    rsp_out_id,
   input  logic [tsm_pkg::PAY_W-1:0]   rsp_out_payload,
   input  logic                        rsp_dropped,
   input  logic                        rsp_last_of_run,
   input  logic                        csr_write_enable,
   input  logic [tsm_pkg::NCFG_W-1:0]  csr_write_data,
   output int                          error_count,
   output int                          words_pending
);
   import tsm_pkg::*;

   typedef struct {
      logic [TIME_W-1:0] ev_time;
      logic [ID_W-1:0]   ev_id;
      logic [PAY_W-1:0]  ev_payload;
      logic              dropped;
      logic              last_of_run;
   } merged_word_type;

   merged_word_type   expected_words[$];
   entry_type         held_words[$];
   logic [TIME_W-1:0] stream_latest [MAX_STREAMS];
   logic [NCFG_W-1:0] stream_cfg;
   int                reported;

   initial begin
      error_count   = 0;
      words_pending = 0;
      reported      = 0;
   end

   task automatic merge_event(input logic [SIDX_W-1:0] idx, input logic [TIME_W-1:0] t,
                              input logic [ID_W-1:0] own_id, input logic [PAY_W-1:0] pay);
      int                n;
      int                pos;
      int                first_new;
      logic [TIME_W-1:0] mark;
      entry_type         e;
      merged_word_type   w;
      n = (stream_cfg == '0) ? 1 : ((stream_cfg > MAX_STREAMS) ? MAX_STREAMS : stream_cfg);
      if (idx >= n) return;
      stream_latest[idx] = t;
      e.ev_time    = t;
      e.ev_id      = (n > 1) ? ID_W'(idx) : own_id;
      e.ev_payload = pay;
      first_new    = expected_words.size();
      if (held_words.size() >= BUFFER_DEPTH) begin
         w = '{e.ev_time, e.ev_id, e.ev_payload, 1'b1, 1'b0};
         expected_words.push_back(w);
      end else begin
         pos = held_words.size();
         while (pos > 0 && held_words[pos-1].ev_time > t) pos--;
         held_words.insert(pos, e);
      end
      mark = stream_latest[0];
      for (int i = 1; i < n; i++)
         if (stream_latest[i] < mark) mark = stream_latest[i];
      while (held_words.size() > 0 && held_words[0].ev_time <= mark) begin
         e = held_words.pop_front();
         w = '{e.ev_time, e.ev_id, e.ev_payload, 1'b0, 1'b0};
         expected_words.push_back(w);
      end
      if (expected_words.size() > first_new)
         expected_words[expected_words.size()-1].last_of_run = 1'b1;
   endtask

   always @(posedge clock) begin
      merged_word_type w;
      if (reset) begin
         stream_cfg = NCFG_W'(1);
         foreach (stream_latest[i]) stream_latest[i] = '0;
         held_words.delete();
         expected_words.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               error_count++;
               if (reported < 10) begin
                  $display("unexpected word: time %h id %h payload %h dropped %b last %b",
                           rsp_out_time, rsp_out_id, rsp_out_payload, rsp_dropped,
                           rsp_last_of_run);
                  reported++;
               end
            end else begin
               w = expected_words.pop_front();
               if (rsp_out_time !== w.ev_time || rsp_out_id !== w.ev_id ||
                   rsp_out_payload !== w.ev_payload || rsp_dropped !== w.dropped ||
                   rsp_last_of_run !== w.last_of_run) begin
                  error_count++;
                  if (reported < 10) begin
                     $display("word mismatch: expected time %h id %h payload %h drop %b last %b",
                              w.ev_time, w.ev_id, w.ev_payload, w.dropped, w.last_of_run);
                     $display("                    got time %h id %h payload %h drop %b last %b",
                              rsp_out_time, rsp_out_id, rsp_out_payload, rsp_dropped,
                              rsp_last_of_run);
                     reported++;
                  end
               end
            end
         end
         if (start && !busy)
            merge_event(req_stream_index, req_event_time, req_event_own_id, req_event_payload);
         if (csr_write_enable) stream_cfg = csr_write_data;
      end
      words_pending = expected_words.size();
   end

endmodule

@@ sim/timestamp_stream_merger_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_stream_merger_top_tb - stimulus and verdict for the stream merger
// Drives directed events over the timestamp and id extremes, equal and falling
// times and unconfigured streams, then random phases over several stream
// counts, with and without a lagging stream to fill the hold buffer, under
// varying sender idling. A separate scoreboard checks every released word.
// ----------------------------------------------------------------------------
module timestamp_stream_merger_top_tb;
   import tsm_pkg::*;

   localparam int QUIET_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 150;
   localparam int PHASE_ITEMS   = 56;

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               start             = 1'b0;
   logic               busy;
   logic [SIDX_W-1:0]  req_stream_index  = '0;
   logic [TIME_W-1:0]  req_event_time    = '0;
   logic [ID_W-1:0]    req_event_own_id  = '0;
   logic [PAY_W-1:0]   req_event_payload = '0;
   logic               rsp_valid;
   logic [TIME_W-1:0]  rsp_out_time;
   logic [ID_W-1:0]    rsp_out_id;
   logic [PAY_W-1:0]   rsp_out_payload;
   logic               rsp_dropped;
   logic               rsp_last_of_run;
   logic               csr_write_enable  = 1'b0;
   logic [NCFG_W-1:0]  csr_write_data    = '0;

   int                 error_count;
   int                 words_pending;
   int                 idle_pct     = 0;
   int                 active_count = 1;
   int                 quiet_cycles = 0;
   logic [TIME_W-1:0]  src_time [MAX_STREAMS];
   logic [NCFG_W-1:0]  phase_cfg [8] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2, 4'd6, 4'd8};

   timestamp_stream_merger_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_stream_index  (req_stream_index),
      .req_event_time    (req_event_time),
      .req_event_own_id  (req_event_own_id),
      .req_event_payload (req_event_payload),
      .rsp_valid         (rsp_valid),
      .rsp_out_time      (rsp_out_time),
      .rsp_out_id        (rsp_out_id),
      .rsp_out_payload   (rsp_out_payload),
      .rsp_dropped       (rsp_dropped),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   merge_order_check u_order_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_stream_index  (req_stream_index),
      .req_event_time    (req_event_time),
      .req_event_own_id  (req_event_own_id),
      .req_event_payload (req_event_payload),
      .rsp_valid         (rsp_valid),
      .rsp_out_time      (rsp_out_time),
      .rsp_out_id        (rsp_out_id),
      .rsp_out_payload   (rsp_out_payload),
      .rsp_dropped       (rsp_dropped),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .error_count       (error_count),
      .words_pending     (words_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [TIME_W-1:0] pick_time(input logic [TIME_W-1:0] prev);
      int r;
      r = $urandom_range(99, 0);
      if (r < 70) return prev + TIME_W'($urandom_range(12, 0));
      if (r < 82) return prev;
      if (r < 90) return {$urandom, $urandom};
      if (r < 95) return prev - TIME_W'($urandom_range(40, 1));
      if (r < 98) return '1;
      return '0;
   endfunction

   task automatic send_event(input int s, input logic [TIME_W-1:0] t,
                             input logic [ID_W-1:0] id, input logic [PAY_W-1:0] pay);
      int gap;
      gap = 0;
      req_stream_index  <= SIDX_W'(s);
      req_event_time    <= t;
      req_event_own_id  <= id;
      req_event_payload <= pay;
      start             <= 1'b1;
      src_time[s] = t;
      do @(posedge clock); while (busy);
      while ($urandom_range(99, 0) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random(input bit lag, output bit counted);
      int                s;
      logic [TIME_W-1:0] t;
      if ($urandom_range(99, 0) < 4) s = $urandom_range(7, 0);
      else if (lag && active_count > 1)
         s = ($urandom_range(19, 0) == 0) ? 0 : $urandom_range(active_count - 1, 1);
      else s = $urandom_range(active_count - 1, 0);
      t = pick_time(src_time[s]);
      if (lag && s == 0 && $urandom_range(1, 0) == 1) begin
         t = '0;
         for (int i = 1; i < active_count; i++)
            if (src_time[i] > t) t = src_time[i];
      end
      counted = (s < active_count);
      send_event(s, t, ID_W'($urandom_range(255, 0)), $urandom);
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (words_pending != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_streams(input logic [NCFG_W-1:0] v);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_count = (v == '0) ? 1 : ((v > MAX_STREAMS) ? MAX_STREAMS : v);
   endtask

   initial begin
      int cnt;
      bit hit;
      foreach (src_time[i]) src_time[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single stream: extremes, falling and equal times, unknown stream
      send_event(0, '0, 8'h00, '0);
      send_event(0, '1, 8'hff, '1);
      send_event(0, 64'd100, 8'h01, 32'h1234_5678);
      send_event(7, 64'd5, 8'h02, 32'h0);
      send_event(0, 64'd50, 8'h5a, 32'ha5a5_a5a5);
      send_event(0, 64'd50, 8'ha5, 32'h5a5a_5a5a);

      // two streams: hold, equal times in arrival order, unknown stream
      set_streams(4'd2);
      send_event(0, 64'd200, 8'h09, 32'h1);
      send_event(0, 64'd200, 8'h0a, 32'h2);
      send_event(1, 64'd150, 8'h0b, 32'h3);
      send_event(1, 64'd200, 8'h0c, 32'h4);
      send_event(5, 64'd300, 8'h0d, 32'h5);
      send_event(1, '1, 8'hff, '1);
      send_event(0, '1, 8'h00, '0);
      send_event(1, 64'd10, 8'h11, 32'h6);
      send_event(0, 64'd20, 8'h12, 32'h7);
      send_event(1, 64'd20, 8'h13, 32'h8);

      for (int p = 0; p < 8; p++) begin
         set_streams((p == 6) ? NCFG_W'($urandom_range(15, 0)) : phase_cfg[p]);
         idle_pct = (p % 3 == 1) ? 86 : ((p % 3 == 2) ? 16 : 0);
         cnt = 0;
         while (cnt < PHASE_ITEMS) begin
            send_random(p[0], hit);
            if (hit) cnt++;
         end
      end

      settle();
      if (error_count == 0 && words_pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
